### hw/rtl/level_set_reinit_step_assert.svh
// ----------------------------------------------------------------------------
// level_set_reinit_step_assert.svh
// Assertion macros used by the level-set reinitialisation command queue.
// ----------------------------------------------------------------------------
`ifndef LEVEL_SET_REINIT_STEP_ASSERT_SVH
`define LEVEL_SET_REINIT_STEP_ASSERT_SVH

`ifndef SYNTHESIS

// implication checked on the same edge
`define LSR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("level_set_reinit_step: assertion failed");

// implication checked on the following edge
`define LSR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("level_set_reinit_step: assertion failed");

`else

`define LSR_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define LSR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg
// Types and constants of the level-set reinitialisation step.
// ----------------------------------------------------------------------------
`default_nettype none

package lsr_pkg;

   // sample format, signed Q16.16
   localparam int SAMPLE_W  = 32;
   localparam int ROW_W     = 16;
   localparam int ONE_Q16   = 65536;
   localparam logic [30:0] MAG_LIMIT = 31'h7fff_ffff;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_DRAIN  = 1'b1
   } lsr_op_type;

   typedef enum logic [1:0] {
      CSR_INV_SPACING   = 2'd0,
      CSR_TIME_STEP     = 2'd1,
      CSR_COLUMN_LENGTH = 2'd2,
      CSR_COLUMN_COUNT  = 2'd3
   } lsr_csr_type;

   typedef struct packed {
      lsr_op_type                  opcode;
      logic signed [SAMPLE_W-1:0]  sample;
   } lsr_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  new_value;
      logic                        last_point;
   } lsr_rsp_type;

   typedef struct packed {
      logic [23:0] inv_spacing;
      logic [15:0] time_step;
      logic [10:0] column_length;
      logic [15:0] column_count;
   } lsr_cfg_type;

   // work for the back end: evaluate a point and/or store a sample
   typedef struct packed {
      logic                        emit;
      logic                        wr;
      logic [ROW_W-1:0]            row;
      logic                        par;       // parity of the incoming column
      logic                        first;
      logic                        row_end;
      logic                        has_left;
      logic                        has_right;
      logic                        last;
      logic signed [SAMPLE_W-1:0]  right;
   } lsr_cmd_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_READ,
      BK_DIFF,
      BK_MUL,
      BK_MAG,
      BK_SQUARE,
      BK_MAX,
      BK_SUM,
      BK_ROOT,
      BK_STEP,
      BK_RESULT,
      BK_WRITE
   } lsr_back_state_type;

endpackage

`default_nettype wire

### hw/rtl/lsr_ram.sv
// ----------------------------------------------------------------------------
// lsr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/lsr_front.sv
// ----------------------------------------------------------------------------
// lsr_front
// Accepts items, tracks the grid position and issues back-end commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_front #(
   parameter int MAX_COLUMN_LENGTH = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire lsr_pkg::lsr_req_type req_data,
   input  wire lsr_pkg::lsr_cfg_type cfg,
   input  wire logic                q_full,
   output logic                     q_push,
   output lsr_pkg::lsr_cmd_type     q_data
);

   import lsr_pkg::*;

   localparam int RW = (MAX_COLUMN_LENGTH > 1) ? $clog2(MAX_COLUMN_LENGTH) : 1;
   localparam int MW = $clog2(MAX_COLUMN_LENGTH + 1);

   logic [RW-1:0] row_ff, row_in;
   logic [15:0]   col_ff, col_in;
   logic [MW-1:0] m_eff;
   logic [15:0]   n_eff;
   logic          accept;
   logic          row_lt_m;
   logic          row_wrap;
   int unsigned   row_nxt;

   // effective geometry, clamped
   always_comb begin
      if (cfg.column_length < 11'd2) begin
         m_eff = MW'(2);
      end else if (32'(cfg.column_length) > 32'(MAX_COLUMN_LENGTH)) begin
         m_eff = MW'(MAX_COLUMN_LENGTH);
      end else begin
         m_eff = MW'(cfg.column_length);
      end
      n_eff = (cfg.column_count < 16'd2) ? 16'd2 : cfg.column_count;
   end

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;
   assign row_lt_m  = 32'(row_ff) < 32'(m_eff);
   assign row_nxt   = 32'(row_ff) + 32'd1;
   assign row_wrap  = row_nxt >= 32'(m_eff);

   // classify item and advance position
   always_comb begin
      row_in          = row_ff;
      col_in          = col_ff;
      q_push          = 1'b0;
      q_data.emit     = 1'b0;
      q_data.wr       = 1'b0;
      q_data.row      = ROW_W'(row_ff);
      q_data.par      = col_ff[0];
      q_data.first    = (row_ff == '0);
      q_data.row_end  = (row_nxt >= 32'(m_eff));
      q_data.has_left = (col_ff >= 16'd2);
      q_data.has_right = 1'b1;
      q_data.last     = 1'b0;
      q_data.right    = req_data.sample;
      if (accept) begin
         case (req_data.opcode)
            OP_SAMPLE: begin
               if (col_ff < n_eff) begin
                  q_data.emit = row_lt_m && (col_ff != 16'd0);
                  q_data.wr   = row_lt_m;
                  q_push      = row_lt_m;
                  if (row_wrap) begin
                     row_in = '0;
                     col_in = col_ff + 16'd1;
                  end else begin
                     row_in = RW'(row_nxt);
                  end
               end
            end
            OP_DRAIN: begin
               if (col_ff >= n_eff) begin
                  if (!row_lt_m) begin
                     row_in = '0;
                     col_in = '0;
                  end else begin
                     q_data.emit      = 1'b1;
                     q_data.has_right = 1'b0;
                     q_data.right     = '0;
                     q_data.last      = row_wrap;
                     q_push           = 1'b1;
                     if (row_wrap) begin
                        row_in = '0;
                        col_in = '0;
                     end else begin
                        row_in = RW'(row_nxt);
                     end
                  end
               end
            end
            default: begin
               row_in = row_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/lsr_cmd_queue.sv
// ----------------------------------------------------------------------------
// lsr_cmd_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "level_set_reinit_step_assert.svh"

module lsr_cmd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire lsr_pkg::lsr_cmd_type push_data,
   input  wire logic                pop,
   output lsr_pkg::lsr_cmd_type     head,
   output logic                     full,
   output logic                     empty
);

   import lsr_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   lsr_cmd_type   mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `LSR_ASSERT_SAME(a_no_push_full, clock, reset, push, !full)
   `LSR_ASSERT_SAME(a_no_pop_empty, clock, reset, pop, !empty)
   `LSR_ASSERT_NEXT(a_fill_step, clock, reset, push && !pop, count_ff == $past(count_ff) + CW'(1))

endmodule

`default_nettype wire

### hw/rtl/lsr_back.sv
// ----------------------------------------------------------------------------
// lsr_back
// Sequenced point evaluation: neighbour reads, upwind squares, root, update.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_back #(
   parameter int MAX_COLUMN_LENGTH = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lsr_pkg::lsr_cfg_type cfg,
   input  wire logic                q_empty,
   input  wire lsr_pkg::lsr_cmd_type q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output lsr_pkg::lsr_rsp_type     rsp_data
);

   import lsr_pkg::*;

   localparam int DEPTH = 2 * MAX_COLUMN_LENGTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = (MAX_COLUMN_LENGTH > 1) ? $clog2(MAX_COLUMN_LENGTH) : 1;

   lsr_back_state_type state_ff, state_in;
   logic [4:0]         cnt_ff, cnt_in;
   lsr_cmd_type        cmd_ff, cmd_in;
   logic [SAMPLE_W-1:0] val_ff [4];
   logic [SAMPLE_W-1:0] val_in [4];
   logic [32:0]        diff_ff [4];
   logic [32:0]        diff_in [4];
   logic [3:0]         use_ff, use_in;
   logic [40:0]        hi_ff, hi_in;
   logic [39:0]        lo_ff, lo_in;
   logic [30:0]        mag_ff [4];
   logic [30:0]        mag_in [4];
   logic [61:0]        sq_ff [4];
   logic [61:0]        sq_in [4];
   logic [61:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic [63:0]        rad_ff, rad_in;
   logic [33:0]        rem_ff, rem_in;
   logic [31:0]        root_ff, root_in;
   logic [48:0]        prod_ff, prod_in;
   logic               hneg_ff, hneg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lsr_rsp_type        rsp_ff, rsp_in;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   logic               out_free;

   logic [32:0]        cx, ad;
   logic [32:0]        d [4];
   logic [35:0]        rem_t, trial;
   logic [33:0]        h;
   logic [32:0]        ha;
   logic [41:0]        q;
   logic [34:0]        r;
   logic [RW-1:0]      row;

   function automatic logic [AW-1:0] slot(input logic par, input logic [RW-1:0] rw);
      slot = par ? AW'(MAX_COLUMN_LENGTH) + AW'(rw) : AW'(rw);
   endfunction

   function automatic logic pos(input logic [32:0] x);
      pos = !x[32] && (x != '0);
   endfunction

   lsr_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(cmd_ff.right),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign row       = cmd_ff.row[RW-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = q_head.emit ? BK_READ : BK_WRITE;
            end
         end
         BK_READ:   if (cnt_ff == 5'd4) state_in = BK_DIFF;
         BK_DIFF:   state_in = BK_MUL;
         BK_MUL:    state_in = BK_MAG;
         BK_MAG:    state_in = (cnt_ff == 5'd3) ? BK_SQUARE : BK_MUL;
         BK_SQUARE: if (cnt_ff == 5'd3) state_in = BK_MAX;
         BK_MAX:    state_in = BK_SUM;
         BK_SUM:    state_in = BK_ROOT;
         BK_ROOT:   if (cnt_ff == 5'd31) state_in = BK_STEP;
         BK_STEP:   state_in = BK_RESULT;
         BK_RESULT: begin
            if (out_free) begin
               state_in = cmd_ff.wr ? BK_WRITE : BK_IDLE;
            end
         end
         BK_WRITE:  state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // neighbour differences from the fetched values
   always_comb begin
      cx   = {val_ff[0][SAMPLE_W-1], val_ff[0]};
      d[1] = cmd_ff.first   ? {val_ff[2][SAMPLE_W-1], val_ff[2]} - cx :
             cmd_ff.row_end ? cx - {val_ff[1][SAMPLE_W-1], val_ff[1]} :
                              {val_ff[2][SAMPLE_W-1], val_ff[2]} - cx;
      d[0] = (cmd_ff.first || cmd_ff.row_end) ? d[1] :
             cx - {val_ff[1][SAMPLE_W-1], val_ff[1]};
      d[3] = (!cmd_ff.has_left || cmd_ff.has_right) ?
             {cmd_ff.right[SAMPLE_W-1], cmd_ff.right} - cx :
             cx - {val_ff[3][SAMPLE_W-1], val_ff[3]};
      d[2] = (!cmd_ff.has_left || !cmd_ff.has_right) ? d[3] :
             cx - {val_ff[3][SAMPLE_W-1], val_ff[3]};
   end

   // datapath and outputs
   always_comb begin
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      val_in       = val_ff;
      diff_in      = diff_ff;
      use_in       = use_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      mag_in       = mag_ff;
      sq_in        = sq_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      prod_in      = prod_ff;
      hneg_in      = hneg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot(cmd_ff.par, row);
      rd_en        = 1'b0;
      rd_addr      = slot(~cmd_ff.par, row);
      ad           = diff_ff[cnt_ff[1:0]][32] ? ~diff_ff[cnt_ff[1:0]] + 33'd1
                                               : diff_ff[cnt_ff[1:0]];
      q            = 42'(hi_ff) + 42'(lo_ff[39:16]);
      rem_t        = {rem_ff, rad_ff[63:62]};
      trial        = {2'b00, root_ff, 2'b01};
      h            = hneg_ff ? 34'(ONE_Q16) - {2'b00, root_ff}
                             : {2'b00, root_ff} - 34'(ONE_Q16);
      h            = val_ff[0][SAMPLE_W-1] ? 34'(ONE_Q16) - {2'b00, root_ff}
                                            : {2'b00, root_ff} - 34'(ONE_Q16);
      ha           = h[33] ? 33'(~h + 34'd1) : h[32:0];
      r            = hneg_ff ? {{3{val_ff[0][SAMPLE_W-1]}}, val_ff[0]} + {2'b00, prod_ff[48:16]}
                             : {{3{val_ff[0][SAMPLE_W-1]}}, val_ff[0]} - {2'b00, prod_ff[48:16]};
      case (state_ff)
         BK_IDLE: begin
            cnt_in = '0;
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
            end
         end
         BK_READ: begin
            // centre, above, below, left; read data arrives in the cycle after its address
            rd_en = 1'b1;
            case (cnt_ff)
               5'd0: rd_addr = slot(~cmd_ff.par, row);
               5'd1: rd_addr = slot(~cmd_ff.par, cmd_ff.first ? row : row - RW'(1));
               5'd2: rd_addr = slot(~cmd_ff.par, cmd_ff.row_end ? row : row + RW'(1));
               default: rd_addr = slot(cmd_ff.par, row);
            endcase
            if (cnt_ff != 5'd0) begin
               val_in[cnt_ff[1:0] - 2'd1] = rd_data;
            end
            cnt_in = cnt_ff + 5'd1;
         end
         BK_DIFF: begin
            diff_in = d;
            if (val_ff[0][SAMPLE_W-1]) begin
               use_in = {pos(d[3]), d[2][32], pos(d[1]), d[0][32]};
            end else begin
               use_in = {d[3][32], pos(d[2]), d[1][32], pos(d[0])};
            end
            cnt_in = '0;
         end
         BK_MUL: begin
            hi_in = 41'(ad[32:16]) * 41'(cfg.inv_spacing);
            lo_in = 40'(ad[15:0]) * 40'(cfg.inv_spacing);
         end
         BK_MAG: begin
            mag_in[cnt_ff[1:0]] = (q > 42'(MAG_LIMIT)) ? MAG_LIMIT : q[30:0];
            cnt_in = (cnt_ff == 5'd3) ? 5'd0 : cnt_ff + 5'd1;
         end
         BK_SQUARE: begin
            sq_in[cnt_ff[1:0]] = use_ff[cnt_ff[1:0]] ?
               62'(mag_ff[cnt_ff[1:0]]) * 62'(mag_ff[cnt_ff[1:0]]) : '0;
            cnt_in = cnt_ff + 5'd1;
         end
         BK_MAX: begin
            ax_in = (sq_ff[0] > sq_ff[1]) ? sq_ff[0] : sq_ff[1];
            ay_in = (sq_ff[2] > sq_ff[3]) ? sq_ff[2] : sq_ff[3];
         end
         BK_SUM: begin
            rad_in  = 64'(ax_ff) + 64'(ay_ff);
            rem_in  = '0;
            root_in = '0;
            cnt_in  = '0;
         end
         BK_ROOT: begin
            // restoring square root, one result bit per cycle
            if (rem_t >= trial) begin
               rem_in  = 34'(rem_t - trial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_t[33:0];
               root_in = {root_ff[30:0], 1'b0};
            end
            rad_in = {rad_ff[61:0], 2'b00};
            cnt_in = cnt_ff + 5'd1;
         end
         BK_STEP: begin
            hneg_in = h[33];
            prod_in = 49'(ha) * 49'(cfg.time_step);
         end
         BK_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.last_point = cmd_ff.last;
               if (!r[34] && (r[33:31] != 3'b000)) begin
                  rsp_in.new_value = {1'b0, {(SAMPLE_W-1){1'b1}}};
               end else if (r[34] && (r[33:31] != 3'b111)) begin
                  rsp_in.new_value = {1'b1, {(SAMPLE_W-1){1'b0}}};
               end else begin
                  rsp_in.new_value = r[SAMPLE_W-1:0];
               end
            end
         end
         BK_WRITE: begin
            wr_en = 1'b1;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      val_ff  <= val_in;
      diff_ff <= diff_in;
      use_ff  <= use_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      mag_ff  <= mag_in;
      sq_ff   <= sq_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      prod_ff <= prod_in;
      hneg_ff <= hneg_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

### hw/rtl/level_set_reinit_step.sv
// ----------------------------------------------------------------------------
// level_set_reinit_step
// One Godunov-upwind reinitialisation step over a streamed 2D level-set grid.
//
// Channels: req_ carries items (grid sample or drain) with valid/stall,
// rsp_ carries updated points with valid/stall, csr_ writes the four
// registers (spacing reciprocal, time step, column length, column count).
// Samples enter column by column; a point is produced when the sample to its
// right arrives, and drain items flush the final column, the last one
// flagged with last_point.
// Path: an accepted item passes the command queue, then the back end makes
// the four store reads, runs the shared scaling multiplier and the square
// root, and registers the point in the result register.
// Flow: the back end works on one item at a time and takes the next from
// the queue only once idle; an item that only stores a sample skips the
// evaluation. A 4-entry command queue lets the front take items while the
// back works. The result register holds one point; while rsp_stall is high
// it holds, the back end waits, and req_stall rises once the queue is full.
// Reset (synchronous) returns the grid position to the origin and the
// registers to their defaults; the line store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module level_set_reinit_step #(
   parameter int MAX_COLUMN_LENGTH = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire lsr_pkg::lsr_req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output lsr_pkg::lsr_rsp_type     rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [23:0]         csr_data
);

   import lsr_pkg::*;

   lsr_cfg_type cfg_ff, cfg_in;
   lsr_cmd_type push_cmd, head_cmd;
   logic        q_push, q_pop, q_full, q_empty;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (lsr_csr_type'(csr_index))
            CSR_INV_SPACING:   cfg_in.inv_spacing   = csr_data;
            CSR_TIME_STEP:     cfg_in.time_step     = csr_data[15:0];
            CSR_COLUMN_LENGTH: cfg_in.column_length = csr_data[10:0];
            CSR_COLUMN_COUNT:  cfg_in.column_count  = csr_data[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_spacing   <= 24'd65536;
         cfg_ff.time_step     <= 16'd16384;
         cfg_ff.column_length <= 11'd2;
         cfg_ff.column_count  <= 16'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsr_front #(
      .MAX_COLUMN_LENGTH(MAX_COLUMN_LENGTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (push_cmd)
   );

   lsr_cmd_queue #(
      .DEPTH(4)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(push_cmd),
      .pop      (q_pop),
      .head     (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   lsr_back #(
      .MAX_COLUMN_LENGTH(MAX_COLUMN_LENGTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (q_empty),
      .q_head   (head_cmd),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
